// File: rtl/pose_rate_median_outlier_filter_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the pose rate filter
// Concurrent checks that compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef POSE_RATE_MEDIAN_OUTLIER_FILTER_ASSERT_SVH
`define POSE_RATE_MEDIAN_OUTLIER_FILTER_ASSERT_SVH
`ifndef SYNTH
`define PRMF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PRMF_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define PRMF_ASSERT(label, clk, rst_n, prop, msg)
`define PRMF_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// File: rtl/prmf_pkg.sv
// ---------------------------------------------------------------------------
// Pose rate filter package
// Widths, constants and control types shared by the filter modules.
// ---------------------------------------------------------------------------
package prmf_pkg;

  localparam int WindowMax = 16;
  localparam int FracBits  = 16;
  localparam int SlotW     = $clog2(WindowMax);
  localparam int CountW    = $clog2(WindowMax + 1);
  localparam int RateW     = 29;
  localparam int VelW      = 48;
  localparam int TurnW     = 20;

  // Pi in Q16 and the rate saturation limits.
  localparam logic signed [19:0] PiQ      = 20'sd205887;
  localparam logic signed [RateW-1:0] RateMax = {1'b0, {(RateW-1){1'b1}}};
  localparam logic signed [RateW-1:0] RateMin = {1'b1, {(RateW-1){1'b0}}};

  // Configuration register indexes.
  localparam logic [1:0] RegWindow    = 2'd0;
  localparam logic [1:0] RegThreshold = 2'd1;
  localparam logic [1:0] RegRate      = 2'd2;

  // Controller states.
  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StCalc  = 7'b0000010,
    StLoad  = 7'b0000100,
    StSort  = 7'b0001000,
    StPick  = 7'b0010000,
    StOut   = 7'b0100000,
    StWrite = 7'b1000000
  } state_e;

endpackage

// File: rtl/prmf_history_ram.sv
// ---------------------------------------------------------------------------
// Yaw rate history memory
// Single-port-write, one-read synchronous memory with registered read data.
// ---------------------------------------------------------------------------
module prmf_history_ram (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [prmf_pkg::SlotW-1:0]             waddr_i,
  input  logic signed [prmf_pkg::RateW-1:0]      wdata_i,
  input  logic [prmf_pkg::SlotW-1:0]             raddr_i,
  output logic signed [prmf_pkg::RateW-1:0]      rdata_o
);

  logic signed [prmf_pkg::RateW-1:0] mem_q [prmf_pkg::WindowMax];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/pose_rate_median_outlier_filter.sv
// ---------------------------------------------------------------------------
// Pose rate filter with sliding-window median outlier check
// Velocity from pose differences; yaw rate filtered against a window median.
// ---------------------------------------------------------------------------
// Usage: pose samples arrive on the in channel (valid/ready). The first
// sample after reset is only stored; each later one yields one transfer on
// the out channel with x/y velocity, filtered turn rate and a rejected flag.
// Configuration writes take effect at once; the user must make them only
// while idle, as the block itself does not enforce this. For a window
// holding N rates (N from 3 up to 16) the history memory is loaded one
// entry a cycle and then sorted by an odd-even transposition sort of N + 1
// passes; while it holds fewer than three rates both steps are skipped.
// One sample is processed at a time; the next is taken once the result
// has moved into the output register. A stalled receiver holds the result
// in the output register; the block still takes the next sample and then
// waits in its pick state until that result has been transferred.
// Reset clears the previous-sample flag, the history count and slot pointer;
// the history memory needs no clearing since only written entries are read.
// ---------------------------------------------------------------------------
`include "pose_rate_median_outlier_filter_assert.svh"

module pose_rate_median_outlier_filter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [27:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [18:0]  yaw_angle_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [47:0]  x_velocity_o,
  output logic signed [47:0]  y_velocity_o,
  output logic signed [19:0]  turn_rate_centi_o,
  output logic                rejected_o
);

  localparam int SW = prmf_pkg::SlotW;
  localparam int CW = prmf_pkg::CountW;
  localparam int RW = prmf_pkg::RateW;
  localparam int WM = prmf_pkg::WindowMax;

  // Configuration registers.
  logic [4:0]  win_q;
  logic [27:0] thr_q;
  logic [9:0]  hz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= 5'd5;
      thr_q <= 28'd131072;
      hz_q  <= 10'd100;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        prmf_pkg::RegWindow:    win_q <= cfg_data_i[4:0];
        prmf_pkg::RegThreshold: thr_q <= cfg_data_i;
        prmf_pkg::RegRate:      hz_q  <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Effective window length and rate.
  logic [CW-1:0] win_eff;
  logic [10:0]   hz_eff;
  always_comb begin
    if (win_q == 5'd0) win_eff = CW'(1);
    else if (win_q > 5'(WM)) win_eff = CW'(WM);
    else win_eff = CW'(win_q);
    hz_eff = (hz_q == 10'd0) ? 11'd1 : {1'b0, hz_q};
  end

  prmf_pkg::state_e state_q, state_d;
  logic          have_prev_q;
  logic signed [31:0] prev_x_q, prev_y_q;
  logic signed [18:0] prev_yaw_q;
  logic [CW-1:0] count_q;
  logic [SW-1:0] oldest_q;
  logic signed [31:0] x_q, y_q;
  logic signed [18:0] yaw_q;
  logic signed [RW-1:0] rate_q;
  logic signed [47:0] vx_q, vy_q;
  logic signed [RW-1:0] sbuf_q [WM];
  logic [CW-1:0] idx_q;
  logic [CW-1:0] n_q;
  logic          phase_q;
  logic signed [RW-1:0] med_q;
  logic          rej_q;
  logic signed [RW-1:0] filt_q;

  // History memory.
  logic          ram_we;
  logic [SW-1:0] ram_waddr, ram_raddr;
  logic signed [RW-1:0] ram_rdata;

  prmf_history_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rate_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Velocity and yaw rate arithmetic (one multiply per path).
  // The velocity product stays within 43 bits, so it fits the 48-bit
  // velocity outputs without overflow.
  logic signed [32:0] dx, dy;
  logic signed [44:0] px, py;
  logic signed [19:0] dyaw, dyaw_w;
  logic signed [31:0] prate;
  logic signed [RW-1:0] rate_sat;
  always_comb begin
    dx = 33'(x_q) - 33'(prev_x_q);
    dy = 33'(y_q) - 33'(prev_y_q);
    px = 45'(dx) * $signed({1'b0, hz_eff});
    py = 45'(dy) * $signed({1'b0, hz_eff});
    dyaw = 20'(yaw_q) - 20'(prev_yaw_q);
    dyaw_w = dyaw;
    if (dyaw > prmf_pkg::PiQ) dyaw_w = dyaw - 20'(2 * 205887);
    else if (dyaw < -prmf_pkg::PiQ) dyaw_w = dyaw + 20'(2 * 205887);
    prate = 32'(dyaw_w) * $signed({21'd0, hz_eff});
    if (prate > 32'(prmf_pkg::RateMax)) rate_sat = prmf_pkg::RateMax;
    else if (prate < 32'(prmf_pkg::RateMin)) rate_sat = prmf_pkg::RateMin;
    else rate_sat = RW'(prate);
  end

  // Push bookkeeping: count and oldest slot after this push.
  logic [SW-1:0] wslot;
  logic [CW-1:0] cnt_new;
  logic [SW-1:0] old_new;
  always_comb begin
    logic [CW:0] c1;
    logic [SW-1:0] o1;
    if (count_q >= CW'(WM)) begin
      wslot = oldest_q;
      o1 = oldest_q + SW'(1);
      c1 = (CW+1)'(WM);
    end else begin
      wslot = SW'(oldest_q + SW'(count_q));
      o1 = oldest_q;
      c1 = (CW+1)'(count_q) + (CW+1)'(1);
    end
    if (c1 > (CW+1)'(win_eff)) begin
      old_new = SW'(o1 + SW'(c1 - (CW+1)'(win_eff)));
      cnt_new = win_eff;
    end else begin
      old_new = o1;
      cnt_new = CW'(c1);
    end
  end

  // Sort step: odd-even transposition, one pass per cycle.
  logic signed [RW-1:0] sorted [WM];
  always_comb begin
    for (int i = 0; i < WM; i++) sorted[i] = sbuf_q[i];
    for (int i = 0; i < WM - 1; i++) begin
      if ((i[0] == phase_q) && (CW'(i + 1) < n_q) && (sbuf_q[i] > sbuf_q[i+1])) begin
        sorted[i] = sbuf_q[i+1];
        sorted[i+1] = sbuf_q[i];
      end
    end
  end

  // Median pick and threshold compare.
  logic signed [RW-1:0] mid_a, mid_b, med_c;
  logic signed [RW:0]   msum, mdiff;
  always_comb begin
    mid_a = sbuf_q[SW'((n_q >> 1) - CW'(1))];
    mid_b = sbuf_q[SW'(n_q >> 1)];
    msum = (RW+1)'(mid_a) + (RW+1)'(mid_b);
    med_c = n_q[0] ? mid_b : RW'(msum >>> 1);
    mdiff = (RW+1)'(rate_q) - (RW+1)'(med_q);
    if (mdiff < 0) mdiff = -mdiff;
  end

  // Turn rate scaling to 0.01 rad/s with half-away rounding.
  logic [RW-1:0] mag;
  logic [36:0]   scaled;
  logic [20:0]   m;
  always_comb begin
    mag = filt_q[RW-1] ? RW'(-filt_q) : RW'(filt_q);
    scaled = 37'(mag) * 37'd100 + 37'(1 << (prmf_pkg::FracBits - 1));
    m = 21'(scaled >> prmf_pkg::FracBits);
  end

  logic signed [19:0] turn_c;
  always_comb begin
    logic [19:0] lim;
    lim = (m > 21'd524288) ? 20'd524288 : m[19:0];
    if (filt_q[RW-1]) turn_c = -$signed(lim);
    else turn_c = (m > 21'd524287) ? 20'sd524287 : $signed(lim);
  end

  assign in_ready_o = (state_q == prmf_pkg::StIdle);
  assign ram_we     = (state_q == prmf_pkg::StWrite);
  assign ram_waddr  = wslot;
  assign ram_raddr  = SW'(oldest_q + SW'(idx_q));

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      prmf_pkg::StIdle:  if (in_valid_i) state_d = have_prev_q ? prmf_pkg::StCalc
                                                              : prmf_pkg::StIdle;
      prmf_pkg::StCalc:  state_d = prmf_pkg::StWrite;
      prmf_pkg::StWrite: state_d = (cnt_new >= CW'(3)) ? prmf_pkg::StLoad
                                                        : prmf_pkg::StPick;
      prmf_pkg::StLoad:  if (idx_q == n_q) state_d = prmf_pkg::StSort;
      prmf_pkg::StSort:  if (idx_q == n_q) state_d = prmf_pkg::StPick;
      prmf_pkg::StPick:  if (!out_valid_o || out_ready_i) state_d = prmf_pkg::StOut;
      prmf_pkg::StOut:   state_d = prmf_pkg::StIdle;
      default:           state_d = prmf_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prmf_pkg::StIdle;
      have_prev_q <= 1'b0;
      count_q     <= '0;
      oldest_q    <= '0;
      idx_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      // The output register fills in the output state and empties on a transfer.
      if (state_q == prmf_pkg::StOut) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        prmf_pkg::StIdle: if (in_valid_i) begin
          have_prev_q <= 1'b1;
        end
        prmf_pkg::StWrite: begin
          count_q  <= cnt_new;
          oldest_q <= old_new;
          idx_q    <= '0;
        end
        prmf_pkg::StLoad: begin
          idx_q <= (idx_q == n_q) ? '0 : idx_q + CW'(1);
          phase_q <= 1'b0;
        end
        prmf_pkg::StSort: begin
          idx_q   <= (idx_q == n_q) ? '0 : idx_q + CW'(1);
          phase_q <= ~phase_q;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      prmf_pkg::StIdle: if (in_valid_i) begin
        x_q <= pos_x_i;
        y_q <= pos_y_i;
        yaw_q <= yaw_angle_i;
        if (!have_prev_q) begin
          prev_x_q <= pos_x_i;
          prev_y_q <= pos_y_i;
          prev_yaw_q <= yaw_angle_i;
        end
      end
      prmf_pkg::StCalc: begin
        rate_q <= rate_sat;
        vx_q <= 48'(px);
        vy_q <= 48'(py);
      end
      prmf_pkg::StWrite: begin
        n_q <= cnt_new;
        med_q <= rate_sat;
        filt_q <= rate_q;
        rej_q <= 1'b0;
      end
      prmf_pkg::StLoad: begin
        if (idx_q != '0) sbuf_q[SW'(idx_q - CW'(1))] <= ram_rdata;
      end
      prmf_pkg::StSort: begin
        for (int i = 0; i < WM; i++) sbuf_q[i] <= sorted[i];
        if (idx_q == n_q) med_q <= med_c;
      end
      prmf_pkg::StPick: begin
        if (n_q >= CW'(3) && mdiff > (RW+1)'(thr_q)) begin
          filt_q <= med_q;
          rej_q  <= 1'b1;
        end
      end
      prmf_pkg::StOut: begin
        x_velocity_o <= vx_q;
        y_velocity_o <= vy_q;
        turn_rate_centi_o <= turn_c;
        rejected_o <= rej_q;
        prev_x_q <= x_q;
        prev_y_q <= y_q;
        prev_yaw_q <= yaw_q;
      end
      default: ;
    endcase
  end

  `PRMF_ASSERT(a_ready_idle, clk_i, rst_ni, (in_ready_o == (state_q == prmf_pkg::StIdle)), "ready outside idle")
  `PRMF_ASSERT_NEXT(a_out_after, clk_i, rst_ni, (state_q == prmf_pkg::StOut), out_valid_o, "no result after output state")
  `PRMF_ASSERT(a_count_max, clk_i, rst_ni, (count_q <= CW'(WM)), "history count overflow")

endmodule
